### rtl/mcs_pkg.sv
// ----------------------------------------------------------------------------
// mcs_pkg: shared types and constants of the motor command supervisor
// Command, result and result-kind codes, limits and the beat/state structs.
// ----------------------------------------------------------------------------
package mcs_pkg;

    // command codes
    localparam logic [3:0] CMD_TICK     = 4'd0;
    localparam logic [3:0] CMD_HELLO    = 4'd1;
    localparam logic [3:0] CMD_PING     = 4'd2;
    localparam logic [3:0] CMD_ARM      = 4'd3;
    localparam logic [3:0] CMD_DISARM   = 4'd4;
    localparam logic [3:0] CMD_STOP     = 4'd5;
    localparam logic [3:0] CMD_ESTOP    = 4'd6;
    localparam logic [3:0] CMD_RESET    = 4'd7;
    localparam logic [3:0] CMD_STATUS   = 4'd8;
    localparam logic [3:0] CMD_SETCFG   = 4'd9;
    localparam logic [3:0] CMD_DRIVE    = 4'd10;
    localparam logic [3:0] CMD_UNKNOWN  = 4'd11;
    localparam logic [3:0] CMD_BADFRAME = 4'd12;

    // result kinds
    localparam logic [2:0] K_ACK      = 3'd0;
    localparam logic [2:0] K_NAK      = 3'd1;
    localparam logic [2:0] K_HELLO    = 3'd2;
    localparam logic [2:0] K_PONG     = 3'd3;
    localparam logic [2:0] K_STATUS   = 3'd4;
    localparam logic [2:0] K_EV_ESTOP = 3'd5;
    localparam logic [2:0] K_EV_WD    = 3'd6;

    // nak reasons
    localparam logic [2:0] R_NONE     = 3'd0;
    localparam logic [2:0] R_BADCS    = 3'd1;
    localparam logic [2:0] R_FAULT    = 3'd2;
    localparam logic [2:0] R_BADARGS  = 3'd3;
    localparam logic [2:0] R_NOTARMED = 3'd4;
    localparam logic [2:0] R_UNKNOWN  = 3'd5;

    // run modes
    localparam logic [1:0] RM_DISARMED = 2'd0;
    localparam logic [1:0] RM_ARMED    = 2'd1;
    localparam logic [1:0] RM_FAULT    = 2'd2;

    // setcfg targets
    localparam logic [1:0] SEL_SPEED   = 2'd0;
    localparam logic [1:0] SEL_TIMEOUT = 2'd1;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_WATCHDOG = 2'd1;
    localparam logic [1:0] ERR_ESTOP    = 2'd2;

    localparam logic [6:0]         MAX_SPEED       = 7'd100;
    localparam logic [10:0]        MIN_TIMEOUT     = 11'd100;
    localparam logic [10:0]        MAX_TIMEOUT     = 11'd2000;
    localparam logic [6:0]         RST_SPEED_LIMIT = 7'd60;
    localparam logic [10:0]        RST_TIMEOUT     = 11'd500;
    localparam logic signed [14:0] SEQ_WRAP        = 15'sd10000;
    localparam logic [15:0]        ELAPSED_MAX     = 16'hFFFF;

    localparam int QDEPTH = 4;

    typedef struct packed {
        logic [3:0]         mode;
        logic signed [14:0] seq;
        logic [1:0]         arg_num;
        logic signed [15:0] value_a;
        logic signed [15:0] value_b;
        logic [1:0]         cfg_select;
    } t_cmd;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [14:0] seq_out;
        logic [3:0]         about;
        logic [2:0]         reason;
        logic [1:0]         run_mode;
        logic signed [7:0]  left_out;
        logic signed [7:0]  right_out;
        logic [10:0]        timeout_out;
        logic [1:0]         error_out;
        logic [15:0]        elapsed_out;
        logic               last;
    } t_res;

    typedef struct packed {
        logic [1:0]        run_state;
        logic signed [7:0] left_speed;
        logic signed [7:0] right_speed;
        logic [1:0]        error_code;
        logic [15:0]       elapsed_ms;
        logic              watchdog_fired;
        logic [6:0]        speed_limit;
        logic [10:0]       timeout_limit;
    } t_state;

endpackage

### rtl/mcs_if.sv
// ----------------------------------------------------------------------------
// mcs_if: command and result channel interfaces
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface mcs_cmd_if;
    logic               valid;
    logic               ready;
    logic [3:0]         mode;
    logic signed [14:0] seq;
    logic [1:0]         arg_num;
    logic signed [15:0] value_a;
    logic signed [15:0] value_b;
    logic [1:0]         cfg_select;

    modport source (output valid, mode, seq, arg_num, value_a, value_b, cfg_select,
                    input ready);
    modport sink   (input valid, mode, seq, arg_num, value_a, value_b, cfg_select,
                    output ready);
endinterface

interface mcs_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic signed [14:0] seq_out;
    logic [3:0]         about;
    logic [2:0]         reason;
    logic [1:0]         run_mode;
    logic signed [7:0]  left_out;
    logic signed [7:0]  right_out;
    logic [10:0]        timeout_out;
    logic [1:0]         error_out;
    logic [15:0]        elapsed_out;
    logic               last;

    modport source (output valid, kind, seq_out, about, reason, run_mode, left_out,
                    right_out, timeout_out, error_out, elapsed_out, last,
                    input ready);
    modport sink   (input valid, kind, seq_out, about, reason, run_mode, left_out,
                    right_out, timeout_out, error_out, elapsed_out, last,
                    output ready);
endinterface

### rtl/mcs_decide.sv
// ----------------------------------------------------------------------------
// mcs_decide: command decode and state update
// Computes the next supervisor state and up to two results for one beat.
// ----------------------------------------------------------------------------
module mcs_decide (
    input  mcs_pkg::t_cmd   i_cmd,
    input  mcs_pkg::t_state i_state,
    output mcs_pkg::t_state o_state,
    output mcs_pkg::t_res   o_res0,
    output mcs_pkg::t_res   o_res1,
    output logic [1:0]      o_count
);
    import mcs_pkg::*;

    logic signed [14:0] s10k;
    logic               quiet;
    logic               args_ok;
    logic [15:0]        elapsed_inc;
    logic signed [15:0] lim_pos;
    logic signed [15:0] lim_neg;
    logic signed [7:0]  left_clamp;
    logic signed [7:0]  right_clamp;
    logic [6:0]         speed_set;
    logic [10:0]        timeout_set;
    t_state             ns;
    logic               p_emit;
    logic               p_zero;
    logic [2:0]         p_kind;
    logic [3:0]         p_about;
    logic [2:0]         p_reason;
    logic               e_emit;
    t_res               base_res;
    t_res               p_res;
    t_res               e_res;

    // C-style truncating remainder; |seq| < 2 * 10000
    always_comb begin
        if (i_cmd.seq >= SEQ_WRAP) begin
            s10k = i_cmd.seq - SEQ_WRAP;
        end else if (i_cmd.seq <= -SEQ_WRAP) begin
            s10k = i_cmd.seq + SEQ_WRAP;
        end else begin
            s10k = i_cmd.seq;
        end
    end

    assign quiet       = i_cmd.seq[14];
    assign args_ok     = i_cmd.arg_num[1];
    assign elapsed_inc = (i_state.elapsed_ms != ELAPSED_MAX) ? i_state.elapsed_ms + 16'd1
                                                              : i_state.elapsed_ms;
    assign lim_pos     = $signed({9'd0, i_state.speed_limit});
    assign lim_neg     = -lim_pos;

    always_comb begin
        if (i_cmd.value_a > lim_pos) begin
            left_clamp = lim_pos[7:0];
        end else if (i_cmd.value_a < lim_neg) begin
            left_clamp = lim_neg[7:0];
        end else begin
            left_clamp = i_cmd.value_a[7:0];
        end
        if (i_cmd.value_b > lim_pos) begin
            right_clamp = lim_pos[7:0];
        end else if (i_cmd.value_b < lim_neg) begin
            right_clamp = lim_neg[7:0];
        end else begin
            right_clamp = i_cmd.value_b[7:0];
        end
        if (i_cmd.value_b > $signed({9'd0, MAX_SPEED})) begin
            speed_set = MAX_SPEED;
        end else if (i_cmd.value_b[15]) begin
            speed_set = 7'd0;
        end else begin
            speed_set = i_cmd.value_b[6:0];
        end
        if (i_cmd.value_b < $signed({5'd0, MIN_TIMEOUT})) begin
            timeout_set = MIN_TIMEOUT;
        end else if (i_cmd.value_b > $signed({5'd0, MAX_TIMEOUT})) begin
            timeout_set = MAX_TIMEOUT;
        end else begin
            timeout_set = i_cmd.value_b[10:0];
        end
    end

    always_comb begin
        ns       = i_state;
        p_emit   = 1'b0;
        p_zero   = 1'b0;
        p_kind   = K_ACK;
        p_about  = i_cmd.mode;
        p_reason = R_NONE;
        e_emit   = 1'b0;
        case (i_cmd.mode)
            CMD_TICK: begin
                ns.elapsed_ms = elapsed_inc;
                if (i_state.run_state == RM_ARMED &&
                    elapsed_inc > {5'd0, i_state.timeout_limit}) begin
                    ns.left_speed  = 8'sd0;
                    ns.right_speed = 8'sd0;
                    ns.run_state   = RM_DISARMED;
                    ns.error_code  = ERR_WATCHDOG;
                    if (!i_state.watchdog_fired) begin
                        ns.watchdog_fired = 1'b1;
                        p_emit = 1'b1;
                        p_zero = 1'b1;
                        p_kind = K_EV_WD;
                    end
                end
            end
            CMD_HELLO: begin
                ns.run_state      = RM_DISARMED;
                ns.error_code     = ERR_NONE;
                ns.watchdog_fired = 1'b0;
                ns.left_speed     = 8'sd0;
                ns.right_speed    = 8'sd0;
                ns.elapsed_ms     = 16'd0;
                p_emit = 1'b1;
                p_kind = K_HELLO;
            end
            CMD_PING: begin
                ns.elapsed_ms = 16'd0;
                p_emit = 1'b1;
                p_kind = K_PONG;
            end
            CMD_ARM: begin
                p_emit = !quiet;
                if (i_state.run_state == RM_FAULT) begin
                    p_kind   = K_NAK;
                    p_reason = R_FAULT;
                end else begin
                    ns.run_state  = RM_ARMED;
                    ns.elapsed_ms = 16'd0;
                end
            end
            CMD_DISARM: begin
                ns.run_state   = RM_DISARMED;
                ns.left_speed  = 8'sd0;
                ns.right_speed = 8'sd0;
                ns.elapsed_ms  = 16'd0;
                p_emit = !quiet;
            end
            CMD_STOP: begin
                ns.left_speed  = 8'sd0;
                ns.right_speed = 8'sd0;
                ns.elapsed_ms  = 16'd0;
                p_emit = !quiet;
            end
            CMD_ESTOP: begin
                ns.run_state   = RM_FAULT;
                ns.error_code  = ERR_ESTOP;
                ns.left_speed  = 8'sd0;
                ns.right_speed = 8'sd0;
                p_emit = !quiet;
                e_emit = 1'b1;
            end
            CMD_RESET: begin
                p_emit = !quiet;
                if (i_state.run_state != RM_FAULT) begin
                    p_kind   = K_NAK;
                    p_reason = R_BADARGS;
                end else begin
                    ns.run_state   = RM_DISARMED;
                    ns.error_code  = ERR_NONE;
                    ns.left_speed  = 8'sd0;
                    ns.right_speed = 8'sd0;
                end
            end
            CMD_STATUS: begin
                ns.elapsed_ms = 16'd0;
                p_emit = 1'b1;
                p_kind = K_STATUS;
            end
            CMD_SETCFG: begin
                p_emit = !quiet;
                if (!args_ok || i_cmd.cfg_select[1]) begin
                    p_kind   = K_NAK;
                    p_reason = R_BADARGS;
                end else if (i_cmd.cfg_select == SEL_SPEED) begin
                    ns.speed_limit = speed_set;
                end else begin
                    ns.timeout_limit = timeout_set;
                end
            end
            CMD_DRIVE: begin
                p_emit = !quiet;
                if (!args_ok) begin
                    p_kind   = K_NAK;
                    p_reason = R_BADARGS;
                end else if (i_state.run_state == RM_FAULT) begin
                    p_kind   = K_NAK;
                    p_reason = R_FAULT;
                end else if (i_state.run_state != RM_ARMED) begin
                    p_kind   = K_NAK;
                    p_reason = R_NOTARMED;
                end else begin
                    ns.left_speed  = left_clamp;
                    ns.right_speed = right_clamp;
                    ns.elapsed_ms  = 16'd0;
                end
            end
            CMD_BADFRAME: begin
                p_emit   = !quiet;
                p_kind   = K_NAK;
                p_reason = R_BADCS;
            end
            default: begin
                p_emit   = !quiet;
                p_kind   = K_NAK;
                p_about  = CMD_UNKNOWN;
                p_reason = R_UNKNOWN;
            end
        endcase
    end

    always_comb begin
        base_res             = '0;
        base_res.run_mode    = ns.run_state;
        base_res.left_out    = ns.left_speed;
        base_res.right_out   = ns.right_speed;
        base_res.timeout_out = ns.timeout_limit;
        base_res.error_out   = ns.error_code;
        base_res.elapsed_out = ns.elapsed_ms;

        p_res         = base_res;
        p_res.kind    = p_kind;
        p_res.seq_out = p_zero ? 15'sd0 : s10k;
        p_res.about   = p_about;
        p_res.reason  = p_reason;
        p_res.last    = !e_emit;

        e_res         = base_res;
        e_res.kind    = K_EV_ESTOP;
        e_res.about   = CMD_ESTOP;
        e_res.reason  = R_NONE;
        e_res.last    = 1'b1;
    end

    assign o_state = ns;
    assign o_res0  = p_emit ? p_res : e_res;
    assign o_res1  = e_res;
    assign o_count = {p_emit & e_emit, p_emit ^ e_emit};

endmodule

### rtl/mcs_outq.sv
// ----------------------------------------------------------------------------
// mcs_outq: result queue
// Small register queue; takes up to two results a cycle, gives one a cycle while the reader is ready.
// ----------------------------------------------------------------------------
module mcs_outq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [1:0]    i_push_count,
    input  mcs_pkg::t_res i_push0,
    input  mcs_pkg::t_res i_push1,
    output logic          o_space2,
    output logic          o_valid,
    input  logic          i_ready,
    output mcs_pkg::t_res o_head
);
    import mcs_pkg::*;

    localparam int AW = $clog2(QDEPTH);
    localparam int CW = AW + 1;

    t_res          r_mem [QDEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] n_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW-1:0] n_rd_ptr;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          pop;
    logic [AW-1:0] wr_next;

    assign o_valid  = (r_count != '0);
    assign o_head   = r_mem[r_rd_ptr];
    assign pop      = o_valid && i_ready;
    assign wr_next  = r_wr_ptr + AW'(1);
    assign o_space2 = (r_count <= CW'(QDEPTH - 2) + CW'(pop));

    assign n_wr_ptr = r_wr_ptr + AW'(i_push_count);
    assign n_rd_ptr = r_rd_ptr + AW'(pop);
    assign n_count  = r_count + CW'(i_push_count) - CW'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push0;
        end
        if (i_push_count == 2'd2) begin
            r_mem[wr_next] <= i_push1;
        end
    end

endmodule

### rtl/motor_command_supervisor.sv
// ----------------------------------------------------------------------------
// motor_command_supervisor: two-wheel drive command supervisor
// Arming, wheel speed clamping, watchdog and result generation.
// ----------------------------------------------------------------------------
// Each command or millisecond tick beat lands in an input register and is
// decoded from it once the queue has room for two results; the state (run
// mode, wheel speeds, error, elapsed count, limits) updates in that same
// cycle and the results go to a four-entry output queue. One beat is taken
// per cycle as long as results drain at the rate they are made; an
// emergency stop with a visible sequence makes two results and so uses
// twice the result bandwidth. A result passes through the input register
// and then the queue before it appears on the output. A tick makes a result
// only when it trips the watchdog, and a suppressed ack or nak makes none.
module motor_command_supervisor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcs_cmd_if.sink     i_cmd,
    mcs_res_if.source   o_res
);
    import mcs_pkg::*;

    t_cmd       r_cmd;
    logic       r_cmd_vld;
    logic       n_cmd_vld;
    t_state     r_st;
    t_state     dec_state;
    t_res       dec_res0;
    t_res       dec_res1;
    logic [1:0] dec_count;
    logic [1:0] push_count;
    logic       space2;
    logic       proc;
    logic       in_take;
    t_res       head;

    assign proc         = r_cmd_vld && space2;
    assign i_cmd.ready  = !r_cmd_vld || proc;
    assign in_take      = i_cmd.valid && i_cmd.ready;
    assign n_cmd_vld    = in_take || (r_cmd_vld && !proc);
    assign push_count   = proc ? dec_count : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_vld <= 1'b0;
        end else begin
            r_cmd_vld <= n_cmd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd.mode       <= i_cmd.mode;
            r_cmd.seq        <= i_cmd.seq;
            r_cmd.arg_num    <= i_cmd.arg_num;
            r_cmd.value_a    <= i_cmd.value_a;
            r_cmd.value_b    <= i_cmd.value_b;
            r_cmd.cfg_select <= i_cmd.cfg_select;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.run_state      <= RM_DISARMED;
            r_st.left_speed     <= 8'sd0;
            r_st.right_speed    <= 8'sd0;
            r_st.error_code     <= ERR_NONE;
            r_st.elapsed_ms     <= 16'd0;
            r_st.watchdog_fired <= 1'b0;
            r_st.speed_limit    <= RST_SPEED_LIMIT;
            r_st.timeout_limit  <= RST_TIMEOUT;
        end else if (proc) begin
            r_st <= dec_state;
        end
    end

    mcs_decide u_decide (
        .i_cmd   (r_cmd),
        .i_state (r_st),
        .o_state (dec_state),
        .o_res0  (dec_res0),
        .o_res1  (dec_res1),
        .o_count (dec_count)
    );

    mcs_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (push_count),
        .i_push0      (dec_res0),
        .i_push1      (dec_res1),
        .o_space2     (space2),
        .o_valid      (o_res.valid),
        .i_ready      (o_res.ready),
        .o_head       (head)
    );

    assign o_res.kind        = head.kind;
    assign o_res.seq_out     = head.seq_out;
    assign o_res.about       = head.about;
    assign o_res.reason      = head.reason;
    assign o_res.run_mode    = head.run_mode;
    assign o_res.left_out    = head.left_out;
    assign o_res.right_out   = head.right_out;
    assign o_res.timeout_out = head.timeout_out;
    assign o_res.error_out   = head.error_out;
    assign o_res.elapsed_out = head.elapsed_out;
    assign o_res.last        = head.last;

    // limits stay inside their saturation ranges
    a_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.speed_limit <= MAX_SPEED && r_st.timeout_limit >= MIN_TIMEOUT &&
        r_st.timeout_limit <= MAX_TIMEOUT)
        else $error("speed or timeout limit out of range");

    // wheels only turn while armed
    a_wheels_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.run_state != RM_ARMED |-> r_st.left_speed == 8'sd0 &&
        r_st.right_speed == 8'sd0)
        else $error("wheel speed nonzero while not armed");

    // fault mode always carries the estop error
    a_fault_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.run_state == RM_FAULT |-> r_st.error_code == ERR_ESTOP)
        else $error("fault mode without estop error");

    // state moves only when a beat is decoded
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !proc |=> $stable(r_st))
        else $error("state changed without a decoded beat");

endmodule
